// ----- rtl/core/aasf_pkg.sv -----
package aasf_pkg;

    // Operation codes carried in the mode field
    localparam logic [4:0] MODE_LSL    = 5'd0;
    localparam logic [4:0] MODE_LSR    = 5'd1;
    localparam logic [4:0] MODE_ASR    = 5'd2;
    localparam logic [4:0] MODE_ROR    = 5'd3;
    localparam logic [4:0] MODE_ADD    = 5'd4;
    localparam logic [4:0] MODE_ADC    = 5'd5;
    localparam logic [4:0] MODE_SUB    = 5'd6;
    localparam logic [4:0] MODE_SBC    = 5'd7;
    localparam logic [4:0] MODE_AND    = 5'd8;
    localparam logic [4:0] MODE_BIC    = 5'd9;
    localparam logic [4:0] MODE_ORR    = 5'd10;
    localparam logic [4:0] MODE_EOR    = 5'd11;
    localparam logic [4:0] MODE_NOT    = 5'd12;
    localparam logic [4:0] MODE_MUL    = 5'd13;
    localparam logic [4:0] MODE_BITCMB = 5'd14;
    localparam logic [4:0] MODE_CSEL   = 5'd15;
    localparam logic [4:0] MODE_CTEST  = 5'd16;
    localparam logic [4:0] MODE_PASS   = 5'd17;

    // Shift kinds, the low two bits of the shift modes
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    typedef enum logic [3:0] {
        U_NONE,
        U_SHIFT,
        U_ADD,
        U_SUB,
        U_AND,
        U_BIC,
        U_ORR,
        U_EOR,
        U_NOT,
        U_MUL,
        U_BCMB,
        U_CSEL,
        U_CTEST,
        U_PASS
    } unit_t;

    typedef enum logic [1:0] {
        FK_NONE,
        FK_C,
        FK_NZ,
        FK_NZCV
    } fkind_t;

    typedef struct packed {
        logic [4:0]  mode;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [31:0] operand_mask;
        logic [3:0]  flags_in;
        logic [3:0]  cond_code;
        logic        want_flags;
    } op_t;

    typedef struct packed {
        logic [31:0] result;
        logic [3:0]  flags_out;
        logic        flags_valid;
        logic        cond_met;
        logic        bad_operand;
    } res_t;

    // Decode stage to execute stage
    typedef struct packed {
        unit_t       unit;
        logic [1:0]  shkind;
        logic [5:0]  shamt;
        logic        add_cin;
        fkind_t      fkind;
        logic        met;
        logic        bad;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] m;
    } dec_t;

    // Execute stage to flag/output stage
    typedef struct packed {
        logic [31:0] res;
        logic        c;
        logic        v;
        fkind_t      fkind;
        logic        met;
        logic        bad;
    } exe_t;

endpackage

// ----- rtl/core/aasf_decode.sv -----
module aasf_decode (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    output logic           op_ready,
    input  aasf_pkg::op_t  op,
    output logic           dn_valid,
    input  logic           dn_ready,
    output aasf_pkg::dec_t dec
);
    import aasf_pkg::*;

    typedef enum logic [3:0] {
        CC_EQ, CC_NE, CC_CS, CC_CC, CC_MI, CC_PL, CC_VS, CC_VC,
        CC_HI, CC_LS, CC_GE, CC_LT, CC_GT, CC_LE, CC_R14, CC_R15
    } cond_t;

    logic   valid_reg;
    dec_t   dec_reg;
    dec_t   dec_next;
    logic   cc_def;
    logic   cc_met;
    logic   shift_big;

    // {defined, met} for a condition code against NZCV
    function automatic logic [1:0] cond_eval(input logic [3:0] code, input logic [3:0] fl);
        logic n;
        logic z;
        logic c;
        logic v;
        logic [1:0] r;
        n = fl[3];
        z = fl[2];
        c = fl[1];
        v = fl[0];
        unique case (cond_t'(code))
            CC_EQ:   r = {1'b1, z};
            CC_NE:   r = {1'b1, !z};
            CC_CS:   r = {1'b1, c};
            CC_CC:   r = {1'b1, !c};
            CC_MI:   r = {1'b1, n};
            CC_PL:   r = {1'b1, !n};
            CC_VS:   r = {1'b1, v};
            CC_VC:   r = {1'b1, !v};
            CC_HI:   r = {1'b1, c && !z};
            CC_LS:   r = {1'b1, !c || z};
            CC_GE:   r = {1'b1, n == v};
            CC_LT:   r = {1'b1, n != v};
            CC_GT:   r = {1'b1, !z && (n == v)};
            CC_LE:   r = {1'b1, z || (n != v)};
            default: r = 2'b00;
        endcase
        return r;
    endfunction

    assign {cc_def, cc_met} = cond_eval(op.cond_code, op.flags_in);

    // ROR takes 0..31, the other shifts 0..63
    assign shift_big = (op.mode == MODE_ROR) ? (|op.operand_b[31:5]) : (|op.operand_b[31:6]);

    always_comb
    begin
        dec_next         = '0;
        dec_next.unit    = U_NONE;
        dec_next.fkind   = FK_NONE;
        dec_next.a       = op.operand_a;
        dec_next.b       = op.operand_b;
        dec_next.m       = op.operand_mask;
        dec_next.shamt   = op.operand_b[5:0];
        dec_next.shkind  = op.mode[1:0];
        unique case (op.mode) inside
            MODE_LSL, MODE_LSR, MODE_ASR, MODE_ROR:
            begin
                if (shift_big)
                begin
                    dec_next.bad = 1'b1;
                end
                else
                begin
                    dec_next.unit  = U_SHIFT;
                    dec_next.fkind = op.want_flags ? FK_C : FK_NONE;
                end
            end
            MODE_ADD, MODE_ADC:
            begin
                dec_next.unit    = U_ADD;
                dec_next.add_cin = (op.mode == MODE_ADC) && op.flags_in[1];
                dec_next.fkind   = op.want_flags ? FK_NZCV : FK_NONE;
            end
            MODE_SUB, MODE_SBC:
            begin
                // a + ~b + cin; SBC uses C directly as not-borrow
                dec_next.unit    = U_SUB;
                dec_next.add_cin = (op.mode == MODE_SUB) || op.flags_in[1];
                dec_next.fkind   = op.want_flags ? FK_NZCV : FK_NONE;
            end
            MODE_AND, MODE_BIC, MODE_ORR, MODE_EOR:
            begin
                unique case (op.mode)
                    MODE_AND: dec_next.unit = U_AND;
                    MODE_BIC: dec_next.unit = U_BIC;
                    MODE_ORR: dec_next.unit = U_ORR;
                    default:  dec_next.unit = U_EOR;
                endcase
                dec_next.fkind = op.want_flags ? FK_NZ : FK_NONE;
            end
            MODE_NOT:    dec_next.unit = U_NOT;
            MODE_MUL:    dec_next.unit = U_MUL;
            MODE_BITCMB: dec_next.unit = U_BCMB;
            MODE_CSEL, MODE_CTEST:
            begin
                dec_next.unit = (op.mode == MODE_CSEL) ? U_CSEL : U_CTEST;
                dec_next.bad  = !cc_def;
                dec_next.met  = cc_def && cc_met;
            end
            MODE_PASS:   dec_next.unit = U_PASS;
            default:     dec_next.bad = 1'b1;
        endcase
    end

    assign op_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (op_ready)
        begin
            valid_reg <= op_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_ready && op_valid)
        begin
            dec_reg <= dec_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dec      = dec_reg;

endmodule

// ----- rtl/core/aasf_exec.sv -----
module aasf_exec (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  aasf_pkg::dec_t dec,
    output logic           dn_valid,
    input  logic           dn_ready,
    output aasf_pkg::exe_t exe
);
    import aasf_pkg::*;

    logic               valid_reg;
    exe_t               exe_reg;
    exe_t               exe_next;

    logic [32:0]        lsl_w;
    logic [32:0]        lsr_w;
    logic signed [32:0] asr_w;
    logic [63:0]        ror_w;
    logic               sh_small;
    logic               sh_32;
    logic [31:0]        sh_res;
    logic               sh_c;

    logic [31:0]        add_b;
    logic [32:0]        sum;
    logic [31:0]        prod;

    // Carry lands in bit 32 (LSL) or bit 0 (LSR/ASR) of the widened value
    assign lsl_w    = {1'b0, dec.a} << dec.shamt[4:0];
    assign lsr_w    = {dec.a, 1'b0} >> dec.shamt[4:0];
    assign asr_w    = $signed({dec.a, 1'b0}) >>> dec.shamt[4:0];
    assign ror_w    = {dec.a, dec.a} >> dec.shamt[4:0];
    assign sh_small = !dec.shamt[5];
    assign sh_32    = (dec.shamt == 6'd32);

    always_comb
    begin
        case (dec.shkind)
            SH_LSL:
            begin
                sh_res = sh_small ? lsl_w[31:0] : 32'd0;
                sh_c   = sh_small ? lsl_w[32] : (sh_32 && dec.a[0]);
            end
            SH_LSR:
            begin
                sh_res = sh_small ? lsr_w[32:1] : 32'd0;
                sh_c   = sh_small ? lsr_w[0] : (sh_32 && dec.a[31]);
            end
            SH_ASR:
            begin
                sh_res = sh_small ? asr_w[32:1] : {32{dec.a[31]}};
                sh_c   = sh_small ? asr_w[0] : dec.a[31];
            end
            default:
            begin
                sh_res = ror_w[31:0];
                sh_c   = ror_w[31];
            end
        endcase
    end

    assign add_b = (dec.unit == U_SUB) ? ~dec.b : dec.b;
    assign sum   = {1'b0, dec.a} + {1'b0, add_b} + {32'd0, dec.add_cin};
    assign prod  = dec.a * dec.b;

    always_comb
    begin
        exe_next       = '0;
        exe_next.fkind = dec.fkind;
        exe_next.met   = dec.met;
        exe_next.bad   = dec.bad;
        case (dec.unit)
            U_SHIFT:
            begin
                exe_next.res = sh_res;
                exe_next.c   = sh_c && (dec.shamt != 6'd0);
            end
            U_ADD, U_SUB:
            begin
                exe_next.res = sum[31:0];
                exe_next.c   = sum[32];
                exe_next.v   = (dec.a[31] == add_b[31]) && (sum[31] != dec.a[31]);
            end
            U_AND:   exe_next.res = dec.a & dec.b;
            U_BIC:   exe_next.res = dec.a & ~dec.b;
            U_ORR:   exe_next.res = dec.a | dec.b;
            U_EOR:   exe_next.res = dec.a ^ dec.b;
            U_NOT:   exe_next.res = ~dec.a;
            U_MUL:   exe_next.res = prod;
            U_BCMB:  exe_next.res = (dec.a & ~dec.m) | (dec.b & dec.m);
            U_CSEL:  exe_next.res = dec.met ? dec.a : dec.b;
            U_PASS:  exe_next.res = dec.a;
            default: exe_next.res = 32'd0;
        endcase
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            exe_reg <= exe_next;
        end
    end

    assign dn_valid = valid_reg;
    assign exe      = exe_reg;

endmodule

// ----- rtl/core/aasf_flags.sv -----
module aasf_flags (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  aasf_pkg::exe_t exe,
    output logic           res_valid,
    input  logic           res_ready,
    output aasf_pkg::res_t res
);
    import aasf_pkg::*;

    logic   valid_reg;
    res_t   res_reg;
    res_t   res_next;
    logic   n;
    logic   z;

    assign n = exe.res[31];
    assign z = (exe.res == 32'd0);

    always_comb
    begin
        res_next             = '0;
        res_next.result      = exe.res;
        res_next.cond_met    = exe.met;
        res_next.bad_operand = exe.bad;
        res_next.flags_valid = (exe.fkind != FK_NONE);
        case (exe.fkind)
            FK_C:    res_next.flags_out = {2'b00, exe.c, 1'b0};
            FK_NZ:   res_next.flags_out = {n, z, 2'b00};
            FK_NZCV: res_next.flags_out = {n, z, exe.c, exe.v};
            default: res_next.flags_out = 4'd0;
        endcase
    end

    assign up_ready = !valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

// ----- rtl/core/arm_alu_shifter_flags.sv -----
// ARM-style ALU with barrel shifter and NZCV flags. Takes one request per clock
// while not stalled, through three registered stages: decode and condition
// evaluation, then execute (shifters, 33-bit adder, 32x32 low-word multiply),
// then flag assembly into the output register. The execute stage, with its
// multiplier, sets the clock limit. Each stage holds its item until the next
// frees up; a waiting result stalls the input only once all three stages are
// full, so up to three requests are in flight. There is no state between
// requests.
module arm_alu_shifter_flags (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    output logic          op_ready,
    input  aasf_pkg::op_t op,
    output logic          res_valid,
    input  logic          res_ready,
    output aasf_pkg::res_t res
);
    import aasf_pkg::*;

    logic   dec_valid;
    logic   dec_ready;
    dec_t   dec;
    logic   exe_valid;
    logic   exe_ready;
    exe_t   exe;

    aasf_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op),
        .dn_valid (dec_valid),
        .dn_ready (dec_ready),
        .dec      (dec)
    );

    aasf_exec u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (dec_valid),
        .up_ready (dec_ready),
        .dec      (dec),
        .dn_valid (exe_valid),
        .dn_ready (exe_ready),
        .exe      (exe)
    );

    aasf_flags u_flags (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (exe_valid),
        .up_ready  (exe_ready),
        .exe       (exe),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // A draining output never blocks the input
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> op_ready)
        else $error("input stalled while output drains");

    a_flags_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.flags_valid |-> res.flags_out == 4'd0)
        else $error("flags without flags_valid");

    a_bad_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.bad_operand |-> !res.flags_valid && !res.cond_met)
        else $error("rejected operand with flags or condition");

    a_cond_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.cond_met |-> !res.flags_valid)
        else $error("condition result with flags");

endmodule
